FILE: sv/ala_pkg.sv
package ala_pkg;

	localparam int POOL_SIZE = 256;
	localparam int IDX_W     = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);
	localparam int MAC_W     = 48;
	localparam int ADDR_W    = 32;
	localparam int CFG_IDX_W = 8;
	localparam int FREE_W    = 9;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_START = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_POOL_END   = CFG_IDX_W'(1);

	localparam logic CMD_DISCOVER = 1'b0;
	localparam logic CMD_RELEASE  = 1'b1;

	localparam logic [2:0] ST_ASSIGNED  = 3'd0;
	localparam logic [2:0] ST_ALREADY   = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_RELEASED  = 3'd3;
	localparam logic [2:0] ST_NO_LEASE  = 3'd4;

	typedef struct packed {
		logic             cmd;
		logic [MAC_W-1:0] client_mac;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] lease_addr;
		logic [FREE_W-1:0] free_count;
	} rsp_t;

	// Search word passed from cell to cell: first owner match, first free slot.
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} tok_t;

	// Table update broadcast to every cell.
	typedef struct packed {
		logic             clear_all;
		logic             set;
		logic             clr;
		logic [IDX_W-1:0] idx;
	} wr_t;

endpackage

FILE: sv/ala_cell.sv
module ala_cell
	import ala_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] my_idx,
	input  logic [CNT_W-1:0] count,
	input  logic [MAC_W-1:0] mac,
	input  wr_t              wr,
	input  tok_t             tok_in,
	output tok_t             tok_out
);

	logic             in_use_q;
	logic [MAC_W-1:0] owner_q;
	tok_t             tok_q;
	tok_t             tok_d;
	logic             in_pool;
	logic             hit_here;
	logic             free_here;

	assign in_pool   = {1'b0, my_idx} < count;
	assign hit_here  = in_pool && in_use_q && (owner_q == mac);
	assign free_here = in_pool && !in_use_q;

	// Keep the earliest match and earliest free slot seen so far.
	always_comb begin
		tok_d          = tok_in;
		tok_d.hit      = tok_in.hit || hit_here;
		tok_d.hit_idx  = tok_in.hit ? tok_in.hit_idx : my_idx;
		tok_d.free     = tok_in.free || free_here;
		tok_d.free_idx = tok_in.free ? tok_in.free_idx : my_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
		end else if (wr.clear_all) begin
			in_use_q <= 1'b0;
		end else if (wr.idx == my_idx) begin
			if (wr.set) begin
				in_use_q <= 1'b1;
			end else if (wr.clr) begin
				in_use_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!wr.clear_all && wr.set && (wr.idx == my_idx)) begin
			owner_q <= mac;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: sv/address_lease_allocator.sv
// A request word is taken in S_IDLE; S_SPAN sizes the pool, S_LAUNCH injects the search
// word, which walks the cell chain one slot per cycle during S_SCAN, and S_DONE commits the
// table update and registers the response word once the response register is free.
// One request is handled at a time; the next waits until the table update lands.
// Reset: arst_n clears every lease, the leased count and both pool ends at once.
// A write to either pool end also clears the lease table and the leased count.
module address_lease_allocator
	import ala_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SPAN   = 5'b00010,
		S_LAUNCH = 5'b00100,
		S_SCAN   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] pool_start_q;
	logic [ADDR_W-1:0] pool_end_q;
	logic [ADDR_W-1:0] lo_q;
	logic [ADDR_W-1:0] hi_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  leased_q;
	req_t              req_q;
	tok_t              res_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	tok_t              tok_w [0:POOL_SIZE];
	wr_t               wr;
	logic              cfg_hit;
	logic              rsp_free;
	logic [ADDR_W:0]   span;
	logic [CNT_W-1:0]  leased_d;
	rsp_t              rsp_d;

	// Configuration is always taken; only the two listed registers act.
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && ((cfg_index == REG_POOL_START) ||
		(cfg_index == REG_POOL_END));

	assign req_ready = (state_q == S_IDLE);
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign span = {1'b0, hi_q} - {1'b0, lo_q} + {{ADDR_W{1'b0}}, 1'b1};

	// Inject a fresh search word at the head of the chain for one cycle.
	always_comb begin
		tok_w[0]     = '0;
		tok_w[0].vld = (state_q == S_LAUNCH);
	end

	genvar gi;
	generate
		for (gi = 0; gi < POOL_SIZE; gi++) begin : g_cell
			ala_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.my_idx  (IDX_W'(gi)),
				.count   (count_q),
				.mac     (req_q.client_mac),
				.wr      (wr),
				.tok_in  (tok_w[gi]),
				.tok_out (tok_w[gi+1])
			);
		end
	endgenerate

	// Decide the outcome from the finished search word and build the update.
	always_comb begin
		wr           = '0;
		wr.clear_all = cfg_hit;
		leased_d     = leased_q;
		rsp_d        = '0;
		if (req_q.cmd == CMD_DISCOVER) begin
			if (res_q.hit) begin
				rsp_d.status     = ST_ALREADY;
				rsp_d.lease_addr = lo_q + ADDR_W'(res_q.hit_idx);
			end else if (res_q.free) begin
				rsp_d.status     = ST_ASSIGNED;
				rsp_d.lease_addr = lo_q + ADDR_W'(res_q.free_idx);
				wr.idx           = res_q.free_idx;
				wr.set           = (state_q == S_DONE) && rsp_free;
				leased_d         = leased_q + CNT_W'(1);
			end else begin
				rsp_d.status = ST_EXHAUSTED;
			end
		end else begin
			if (res_q.hit) begin
				rsp_d.status     = ST_RELEASED;
				rsp_d.lease_addr = lo_q + ADDR_W'(res_q.hit_idx);
				wr.idx           = res_q.hit_idx;
				wr.clr           = (state_q == S_DONE) && rsp_free;
				if (leased_q != '0) begin
					leased_d = leased_q - CNT_W'(1);
				end
			end else begin
				rsp_d.status = ST_NO_LEASE;
			end
		end
		rsp_d.free_count = FREE_W'(count_q - leased_d);
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SPAN;
					end
				end
				S_SPAN: begin
					state_q <= S_LAUNCH;
				end
				S_LAUNCH: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// Hold until the search word drops out of the last cell.
					if (tok_w[POOL_SIZE].vld) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// Wait for the response register, then commit.
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Raise the response valid on commit, drop it once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Leased count: cleared by a pool write, updated on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leased_q <= '0;
		end else if (cfg_hit) begin
			leased_q <= '0;
		end else if ((state_q == S_DONE) && rsp_free) begin
			leased_q <= leased_d;
		end
	end

	// Pool ends reset to zero with the rest of the control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_start_q <= '0;
			pool_end_q   <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_POOL_START) begin
				pool_start_q <= cfg_data;
			end else if (cfg_index == REG_POOL_END) begin
				pool_end_q <= cfg_data;
			end
		end
	end

	// Payload registers: request word, pool bounds, search result, response.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			req_q <= req;
			lo_q  <= (pool_start_q < pool_end_q) ? pool_start_q : pool_end_q;
			hi_q  <= (pool_start_q < pool_end_q) ? pool_end_q : pool_start_q;
		end
		if (state_q == S_SPAN) begin
			// Saturate oversized ranges to the table depth.
			count_q <= (span > (ADDR_W+1)'(POOL_SIZE)) ? CNT_W'(POOL_SIZE) : CNT_W'(span);
		end
		if ((state_q == S_SCAN) && tok_w[POOL_SIZE].vld) begin
			res_q <= tok_w[POOL_SIZE];
		end
		if ((state_q == S_DONE) && rsp_free) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

FILE: dv/lease_checker.sv
`timescale 1ns / 100ps

// Watches the request, response and register channels of the lease allocator,
// keeps its own copy of the lease table and compares every response word.
module lease_checker
	import ala_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  rsp_t                 rsp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	output int                   error_count,
	output int                   pending,
	output int                   words_checked,
	output logic [4:0]           status_seen
);

	logic [ADDR_W-1:0] start_addr;
	logic [ADDR_W-1:0] end_addr;
	logic              lease_busy  [POOL_SIZE];
	logic [MAC_W-1:0]  lease_owner [POOL_SIZE];
	int                leased_cnt;
	rsp_t              lease_q[$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, want %0h (response word %0d)",
			what, got, want, words_checked);
		error_count++;
	endtask

	task automatic clear_leases();
		for (int i = 0; i < POOL_SIZE; i++) begin
			lease_busy[i]  = 1'b0;
			lease_owner[i] = '0;
		end
		leased_cnt = 0;
	endtask

	// Work out the response to one request word and update the table.
	task automatic lease_table_step(input req_t r);
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		logic [32:0]       span;
		int                count;
		int                owner_slot;
		int                free_slot;
		rsp_t              e;
		lo = (start_addr < end_addr) ? start_addr : end_addr;
		hi = (start_addr < end_addr) ? end_addr : start_addr;
		span = {1'b0, hi} - {1'b0, lo} + 33'd1;
		count = (span > 33'(POOL_SIZE)) ? POOL_SIZE : int'(span);
		owner_slot = -1;
		free_slot = -1;
		for (int i = 0; i < count; i++) begin
			if (lease_busy[i] && lease_owner[i] == r.client_mac && owner_slot < 0)
				owner_slot = i;
			if (!lease_busy[i] && free_slot < 0)
				free_slot = i;
		end
		e = '0;
		if (r.cmd == CMD_DISCOVER) begin
			if (owner_slot >= 0) begin
				e.status = ST_ALREADY;
				e.lease_addr = lo + ADDR_W'(owner_slot);
			end else if (free_slot >= 0) begin
				lease_busy[free_slot] = 1'b1;
				lease_owner[free_slot] = r.client_mac;
				leased_cnt++;
				e.status = ST_ASSIGNED;
				e.lease_addr = lo + ADDR_W'(free_slot);
			end else begin
				e.status = ST_EXHAUSTED;
			end
		end else begin
			if (owner_slot >= 0) begin
				lease_busy[owner_slot] = 1'b0;
				lease_owner[owner_slot] = '0;
				if (leased_cnt > 0)
					leased_cnt--;
				e.status = ST_RELEASED;
				e.lease_addr = lo + ADDR_W'(owner_slot);
			end else begin
				e.status = ST_NO_LEASE;
			end
		end
		e.free_count = FREE_W'((count >= leased_cnt) ? count - leased_cnt : 0);
		lease_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			start_addr = '0;
			end_addr = '0;
			clear_leases();
			lease_q.delete();
			error_count = 0;
			words_checked = 0;
			status_seen = '0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POOL_START: begin
						start_addr = cfg_data;
						clear_leases();
					end
					REG_POOL_END: begin
						end_addr = cfg_data;
						clear_leases();
					end
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				lease_table_step(req);
			if (rsp_valid && rsp_ready) begin
				if (lease_q.size() == 0) begin
					report_mismatch("response word with nothing expected", rsp, '0);
				end else begin
					want = lease_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
					if (rsp.lease_addr !== want.lease_addr)
						report_mismatch("lease_addr", rsp.lease_addr, want.lease_addr);
					if (rsp.free_count !== want.free_count)
						report_mismatch("free_count", rsp.free_count, want.free_count);
					status_seen[want.status] = 1'b1;
				end
				words_checked++;
			end
			pending <= lease_q.size();
		end
	end

endmodule

FILE: dv/tb_address_lease_allocator.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the address lease allocator. The checker beside the
// block predicts and compares; this module only drives the channels.
module tb_address_lease_allocator;
	import ala_pkg::*;

	// Each request walks the whole cell chain; allow for stalls many times over.
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int SETTLE_CYCLES = 2 * (POOL_SIZE + 5);
	localparam int IDLE_PCT     = 14;
	localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};
	localparam logic [CFG_IDX_W-1:0] BAD_INDEX_TOP = {CFG_IDX_W{1'b1}};

	typedef enum int {
		POOL_ONE,
		POOL_SMALL,
		POOL_REVERSED,
		POOL_WIDE,
		POOL_TOP,
		POOL_FULL
	} pool_shape_e;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		logic [ADDR_W-1:0]    data;
	} reg_write_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data  = '0;

	// Hold both sides busy with no idling while this is set.
	logic calm = 1'b0;

	int error_count;
	int pending;
	int words_checked;
	logic [4:0] status_seen;

	int cycle_count = 0;
	int n_discover = 0;
	int n_release = 0;
	int n_settings = 0;

	reg_write_t       reg_writes[$];
	logic [MAC_W-1:0] clients[16];

	address_lease_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lease_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_count   (error_count),
		.pending       (pending),
		.words_checked (words_checked),
		.status_seen   (status_seen)
	);

	always #1 clk = ~clk;

	// Drop the timeout on a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stall the response side at random, except during the calm stretch.
	always @(negedge clk) begin
		rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		return MAC_W'({$urandom(), $urandom()});
	endfunction

	// Present one request word and hold it until the block takes it.
	// Called and left at a falling edge; valid stays high for a following word.
	task automatic send_request(input logic c, input logic [MAC_W-1:0] mac);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{cmd: c, client_mac: mac};
		if (c == CMD_DISCOVER)
			n_discover++;
		else
			n_release++;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Lower the request valid and hold until every expected response word is back.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Push the queued register writes back to back; only call while idle.
	task automatic apply_reg_writes();
		reg_write_t w;
		while (reg_writes.size() != 0) begin
			w = reg_writes.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Queue the two pool ends for one shape, in random order.
	task automatic plan_pool(input pool_shape_e shape);
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		int                span;
		span = $urandom_range(2, 12);
		a = $urandom_range(0, 32'hFFFF_FF00);
		case (shape)
			POOL_ONE: b = a;
			POOL_SMALL: b = a + ADDR_W'(span - 1);
			POOL_REVERSED: begin
				b = a;
				a = a + ADDR_W'(span - 1);
			end
			POOL_WIDE: begin
				a = $urandom();
				b = $urandom();
			end
			POOL_TOP: begin
				a = ADDR_TOP;
				b = ADDR_TOP - ADDR_W'(span - 1);
			end
			default: b = a + ADDR_W'(POOL_SIZE - 1);
		endcase
		if ($urandom_range(0, 1) == 0) begin
			reg_writes.push_back('{REG_POOL_START, a});
			reg_writes.push_back('{REG_POOL_END, b});
		end else begin
			reg_writes.push_back('{REG_POOL_END, b});
			reg_writes.push_back('{REG_POOL_START, a});
		end
		n_settings++;
	endtask

	initial begin
		logic [MAC_W-1:0] mac;
		logic             c;
		int               n_clients;
		int               n_items;
		int               noise_pct;
		int               noise_disc_pct;
		logic [MAC_W-1:0] mac_a;
		logic [MAC_W-1:0] mac_b;
		logic [MAC_W-1:0] mac_c;
		logic [MAC_W-1:0] mac_d;
		logic [MAC_W-1:0] mac_e;

		mac_a = 48'h0000_0000_0001;
		mac_b = 48'hFFFF_FFFF_FFFE;
		mac_c = 48'h8000_0000_0000;
		mac_d = 48'h5555_5555_5555;
		mac_e = 48'hAAAA_AAAA_AAAA;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset pool is the single address zero: lease, repeat, exhaust, release unowned, release, release again.
		send_request(CMD_DISCOVER, '0);
		send_request(CMD_DISCOVER, '0);
		send_request(CMD_DISCOVER, '1);
		send_request(CMD_RELEASE, '1);
		send_request(CMD_RELEASE, '0);
		send_request(CMD_RELEASE, '0);

		// Reversed ends at the top of the address space: four addresses.
		wait_idle();
		reg_writes.push_back('{REG_POOL_START, ADDR_TOP});
		reg_writes.push_back('{REG_POOL_END, ADDR_TOP - 3});
		apply_reg_writes();
		n_settings++;
		send_request(CMD_DISCOVER, mac_a);
		send_request(CMD_DISCOVER, mac_b);
		send_request(CMD_DISCOVER, mac_c);
		send_request(CMD_DISCOVER, mac_d);
		send_request(CMD_DISCOVER, mac_e);
		// Free the second slot and let the next lease reuse the lowest free one.
		send_request(CMD_RELEASE, mac_b);
		send_request(CMD_DISCOVER, mac_e);

		// A write to an unused index must leave the table alone.
		wait_idle();
		reg_writes.push_back('{BAD_INDEX_TOP, ADDR_TOP});
		apply_reg_writes();
		send_request(CMD_DISCOVER, mac_a);

		// Full 32-bit range saturates to POOL_SIZE addresses from zero.
		wait_idle();
		reg_writes.push_back('{REG_POOL_START, '0});
		reg_writes.push_back('{REG_POOL_END, ADDR_TOP});
		apply_reg_writes();
		n_settings++;
		send_request(CMD_DISCOVER, mac_a);
		send_request(CMD_RELEASE, mac_c);
		send_request(CMD_RELEASE, mac_a);

		// Random phases: a fresh pool shape and client set each, the last one
		// filling a whole POOL_SIZE pool mostly with fresh clients.
		for (int p = 0; p < 11; p++) begin
			wait_idle();
			if (p == 10) begin
				plan_pool(POOL_FULL);
				n_items = 300;
				noise_pct = 85;
				noise_disc_pct = 90;
			end else begin
				plan_pool(pool_shape_e'(p % 6));
				n_items = 80;
				noise_pct = 15;
				noise_disc_pct = 30;
			end
			apply_reg_writes();
			n_clients = $urandom_range(2, 16);
			for (int k = 0; k < 16; k++)
				clients[k] = rand_mac();
			calm <= (p == 2);

			for (int i = 0; i < n_items; i++) begin
				// Hold off now and then until the block has drained.
				if ($urandom_range(0, 99) < 2)
					wait_idle();
				// Once in a while, while idle, rewrite one end or hit an unused index.
				if ($urandom_range(0, 99) == 0) begin
					wait_idle();
					if ($urandom_range(0, 1) == 0)
						reg_writes.push_back('{CFG_IDX_W'($urandom_range(2, 255)), $urandom()});
					else
						reg_writes.push_back('{REG_POOL_END, $urandom()});
					apply_reg_writes();
				end
				if ($urandom_range(0, 99) < noise_pct) begin
					mac = rand_mac();
					c = ($urandom_range(0, 99) < noise_disc_pct) ? CMD_DISCOVER : CMD_RELEASE;
				end else begin
					mac = clients[$urandom_range(0, n_clients - 1)];
					c = ($urandom_range(0, 99) < 55) ? CMD_DISCOVER : CMD_RELEASE;
				end
				send_request(c, mac);
			end
			calm <= 1'b0;
		end

		// Drain, then give any stray word time to show up.
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Summary: %0d requests (%0d discover, %0d release) over %0d pool settings",
			n_discover + n_release, n_discover, n_release, n_settings);
		$display("Summary: %0d response words checked, status kinds seen %b",
			words_checked, status_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: sim.f
sv/ala_pkg.sv
sv/ala_cell.sv
sv/address_lease_allocator.sv
dv/lease_checker.sv
dv/tb_address_lease_allocator.sv
